// File: rtl/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg: shared types and constants of the STFT band energy block
// Sequencer states, band edge tables and the sine series that builds the
// window and twiddle tables during elaboration.
// ----------------------------------------------------------------------------
package sbe_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BF_RD_B,
    ST_BF_RD_A,
    ST_BF_MUL,
    ST_BF_WR_B,
    ST_BF_WR_A,
    ST_MG_RD,
    ST_MG_MUL,
    ST_MG_SUM,
    ST_MG_SQRT,
    ST_EMIT
  } state_t;

  localparam int          BAND_MAX = 24;
  localparam logic [63:0] PI_Q30   = 64'd3373259426;

  localparam logic [7:0] BAND_LO [BAND_MAX] = '{
    8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8, 8'd10, 8'd12, 8'd15, 8'd18, 8'd22,
    8'd26, 8'd32, 8'd39, 8'd47, 8'd57, 8'd69, 8'd83, 8'd100, 8'd120, 8'd144,
    8'd172, 8'd206};
  localparam logic [7:0] BAND_HI [BAND_MAX] = '{
    8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd9, 8'd11, 8'd14, 8'd17, 8'd21, 8'd25,
    8'd31, 8'd38, 8'd46, 8'd56, 8'd68, 8'd82, 8'd99, 8'd119, 8'd143, 8'd171,
    8'd205, 8'd240};

  // Odd Taylor series of sin(x) up to x^17, x in Q2.30, each term truncated.
  function automatic logic signed [63:0] sin_core(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    return sum;
  endfunction

endpackage

// File: rtl/sbe_ram.sv
// ----------------------------------------------------------------------------
// sbe_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sbe_isqrt.sv
// ----------------------------------------------------------------------------
// sbe_isqrt: iterative integer square root
// Truncated square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sbe_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        active_r;
  logic        done_r;
  logic [63:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= 5'd31;
        v_r      <= value;
        r_r      <= '0;
        bit_r    <= 64'd1 << 62;
      end else if (active_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (cnt_r == 5'd0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

// File: rtl/stft_band_energy_top.sv
// ----------------------------------------------------------------------------
// stft_band_energy_top: short-time band energy filterbank
// Hann-windowed fixed-point FFT over captured PCM frames, bin magnitudes by
// integer square root and per-band sums, one result beat per band.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_sample
//  out_    | output    | out_valid/out_stall | frame_number, band_number,
//          |           |                   | energy, last_band
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_data (capture length)
//
// A sample beat that completes a frame holds the input through the load,
// the butterflies on the single work memory and, per band bin, the read,
// the squares and the square root, up to the last band beat.
// Reset is synchronous; output stall delays the band beats and, as the
// input stays held until the last of them, also the next sample.
module stft_band_energy_top #(
  parameter int TRANSFORM_POINTS = 512,
  parameter int HOP_SAMPLES      = 128,
  parameter int BAND_COUNT       = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_frame_number,
  output logic [4:0]  out_band_number,
  output logic [31:0] out_energy,
  output logic        out_last_band,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(TRANSFORM_POINTS);
  localparam int SW = $clog2(AW);

  function automatic logic [15:0] win_val(input int idx);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] x;
    logic [63:0] sq;
    logic [63:0] w;
    logic signed [63:0] s;
    logic neg;
    den = 64'(TRANSFORM_POINTS - 1);
    num = 64'(idx);
    neg = 1'b0;
    if (num >= den) begin
      num = num - den;
      neg = 1'b1;
    end
    if (2 * num > den) num = den - num;
    x = (num * sbe_pkg::PI_Q30) / 64'(TRANSFORM_POINTS - 1);
    s = sbe_pkg::sin_core(x);
    if (neg) s = -s;
    sq = $unsigned(s * s);
    w = (sq + (64'd1 << 44)) >> 45;
    return (w > 64'd32767) ? 16'd32767 : w[15:0];
  endfunction

  function automatic logic signed [16:0] tw_val(input int idx);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] x;
    logic signed [63:0] s;
    logic signed [63:0] r;
    logic neg;
    den = 64'(TRANSFORM_POINTS);
    num = 64'(idx);
    neg = 1'b0;
    if (num >= den) begin
      num = num - den;
      neg = 1'b1;
    end
    if (2 * num > den) num = den - num;
    x = (num * sbe_pkg::PI_Q30) / 64'(TRANSFORM_POINTS);
    s = sbe_pkg::sin_core(x);
    if (neg) s = -s;
    r = (s + 64'sd16384) >>> 15;
    return r[16:0];
  endfunction

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) r[i] = v[AW-1-i];
    return r;
  endfunction

  // The window is symmetric, so only its first half is stored.
  logic [15:0] win_rom [TRANSFORM_POINTS/2];
  logic [33:0] tw_rom  [TRANSFORM_POINTS/2];

  for (genvar gi = 0; gi < TRANSFORM_POINTS / 2; gi++) begin : g_win
    assign win_rom[gi] = win_val(gi);
  end
  for (genvar gi = 0; gi < TRANSFORM_POINTS / 2; gi++) begin : g_tw
    assign tw_rom[gi] = {tw_val(2 * gi + TRANSFORM_POINTS / 2), tw_val(2 * gi)};
  end

  sbe_pkg::state_t state_r, state_nxt;

  logic [15:0]   cap_len_r;
  logic [15:0]   pos_r;
  logic [8:0]    frames_r;
  logic [17:0]   next_r;
  logic [8:0]    frame_num_r;
  logic [AW-1:0] frame_base_r;

  logic [AW:0]   ld_cnt_r;
  logic          v1_r, v2_r;
  logic [AW-1:0] n1_r, n2_r;
  logic [15:0]   win_q_r;
  logic signed [32:0] p1_r;

  logic [SW-1:0] stage_r;
  logic [AW-2:0] bf_r;
  logic [33:0]   tw_q_r;
  logic [63:0]   b_word_r, a_word_r, apt_word_r;
  logic signed [48:0] p_rc_r, p_is_r, p_ic_r, p_rs_r;

  logic [4:0]    band_r;
  logic [7:0]    bin_r;
  logic [39:0]   acc_r;
  logic signed [63:0] sq_re_r, sq_im_r;

  logic          out_valid_r;
  logic [8:0]    out_frame_r;
  logic [4:0]    out_band_r;
  logic [31:0]   out_energy_r;
  logic          out_last_r;

  logic          in_acc;
  logic [16:0]   count;
  logic [16:0]   len17;
  logic          fire;

  logic          s_we;
  logic [AW-1:0] s_raddr;
  logic [15:0]   s_rdata;
  logic          w_we;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [63:0]   w_wdata, w_rdata;

  logic [AW-2:0] win_idx;
  logic [AW-1:0] low_mask, bf_ext, k_idx, a_addr, b_addr;
  logic [AW-2:0] tw_idx;
  logic signed [32:0] ld_sum;
  logic signed [49:0] tr_sum, ti_sum;
  logic signed [31:0] tr, ti;
  logic signed [31:0] a_re, a_im;
  logic          out_free;
  logic          sq_start, sq_done;
  logic [31:0]   sq_root;
  logic [63:0]   sq_value;
  logic          bin_past;
  logic          bin_above;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != sbe_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign count     = {1'b0, pos_r} + 17'd1;
  assign len17     = (cap_len_r == 16'd0) ? 17'h10000 : {1'b0, cap_len_r};
  assign fire      = ({1'b0, count} == next_r) && (count <= len17);
  assign out_free  = !out_valid_r || !out_stall;

  assign win_idx  = ld_cnt_r[AW-1] ? ~ld_cnt_r[AW-2:0] : ld_cnt_r[AW-2:0];
  assign low_mask = (AW'(1) << stage_r) - AW'(1);
  assign bf_ext   = AW'(bf_r);
  assign k_idx    = bf_ext & low_mask;
  assign a_addr   = ((bf_ext & ~low_mask) << 1) | k_idx;
  assign b_addr   = a_addr | (AW'(1) << stage_r);
  assign tw_idx   = (AW-1)'(k_idx << (AW - 1 - int'(stage_r)));

  assign ld_sum = p1_r + 33'sd16384;
  assign a_re   = $signed(a_word_r[63:32]);
  assign a_im   = $signed(a_word_r[31:0]);
  assign tr_sum = 50'(p_rc_r) + 50'(p_is_r) + 50'sd16384;
  assign ti_sum = 50'(p_ic_r) - 50'(p_rs_r) + 50'sd16384;
  assign tr     = 32'(tr_sum >>> 15);
  assign ti     = 32'(ti_sum >>> 15);
  assign sq_value  = $unsigned(sq_re_r) + $unsigned(sq_im_r);
  assign bin_past  = bin_r > sbe_pkg::BAND_HI[band_r];
  assign bin_above = {3'b000, bin_r} >= 11'(TRANSFORM_POINTS / 2);

  sbe_ram #(.WIDTH(16), .DEPTH(TRANSFORM_POINTS)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (in_sample),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  sbe_ram #(.WIDTH(64), .DEPTH(TRANSFORM_POINTS)) u_work_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  sbe_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    s_we      = in_acc;
    s_raddr   = frame_base_r + ld_cnt_r[AW-1:0];
    w_we      = 1'b0;
    w_waddr   = bitrev(n2_r);
    w_wdata   = {32'(ld_sum >>> 15), 32'd0};
    w_raddr   = b_addr;
    sq_start  = 1'b0;
    case (state_r)
      sbe_pkg::ST_IDLE: begin
        if (in_acc && fire) state_nxt = sbe_pkg::ST_LOAD;
      end
      sbe_pkg::ST_LOAD: begin
        w_we = v2_r;
        if (ld_cnt_r == (AW+1)'(TRANSFORM_POINTS) && !v1_r && !v2_r) begin
          state_nxt = sbe_pkg::ST_BF_RD_B;
        end
      end
      sbe_pkg::ST_BF_RD_B: begin
        w_raddr   = b_addr;
        state_nxt = sbe_pkg::ST_BF_RD_A;
      end
      sbe_pkg::ST_BF_RD_A: begin
        w_raddr   = a_addr;
        state_nxt = sbe_pkg::ST_BF_MUL;
      end
      sbe_pkg::ST_BF_MUL: begin
        state_nxt = sbe_pkg::ST_BF_WR_B;
      end
      sbe_pkg::ST_BF_WR_B: begin
        w_we      = 1'b1;
        w_waddr   = b_addr;
        w_wdata   = {a_re - tr, a_im - ti};
        state_nxt = sbe_pkg::ST_BF_WR_A;
      end
      sbe_pkg::ST_BF_WR_A: begin
        w_we    = 1'b1;
        w_waddr = a_addr;
        w_wdata = apt_word_r;
        if (bf_r == '1 && stage_r == SW'(AW - 1)) begin
          state_nxt = sbe_pkg::ST_MG_RD;
        end else begin
          state_nxt = sbe_pkg::ST_BF_RD_B;
        end
      end
      sbe_pkg::ST_MG_RD: begin
        w_raddr = AW'(bin_r);
        if (bin_past) begin
          state_nxt = sbe_pkg::ST_EMIT;
        end else if (!bin_above) begin
          state_nxt = sbe_pkg::ST_MG_MUL;
        end
      end
      sbe_pkg::ST_MG_MUL: begin
        state_nxt = sbe_pkg::ST_MG_SUM;
      end
      sbe_pkg::ST_MG_SUM: begin
        sq_start  = 1'b1;
        state_nxt = sbe_pkg::ST_MG_SQRT;
      end
      sbe_pkg::ST_MG_SQRT: begin
        if (sq_done) state_nxt = sbe_pkg::ST_MG_RD;
      end
      sbe_pkg::ST_EMIT: begin
        if (out_free) begin
          if (band_r == 5'(BAND_COUNT - 1)) begin
            state_nxt = sbe_pkg::ST_IDLE;
          end else begin
            state_nxt = sbe_pkg::ST_MG_RD;
          end
        end
      end
      default: state_nxt = sbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_len_r <= 16'd16000;
      pos_r     <= '0;
      frames_r  <= '0;
      next_r    <= 18'(TRANSFORM_POINTS);
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cap_len_r <= cfg_data;
      if (in_acc) begin
        if (count >= len17) begin
          pos_r    <= '0;
          frames_r <= '0;
          next_r   <= 18'(TRANSFORM_POINTS);
        end else begin
          pos_r <= count[15:0];
          if (fire) begin
            frames_r <= frames_r + 9'd1;
            next_r   <= next_r + 18'(HOP_SAMPLES);
          end
        end
      end
      v1_r <= (state_r == sbe_pkg::ST_LOAD) && (ld_cnt_r < (AW+1)'(TRANSFORM_POINTS));
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    win_q_r <= win_rom[win_idx];
    tw_q_r  <= tw_rom[tw_idx];
    n1_r    <= ld_cnt_r[AW-1:0];
    n2_r    <= n1_r;
    p1_r    <= $signed(s_rdata) * $signed({1'b0, win_q_r});
    case (state_r)
      sbe_pkg::ST_IDLE: begin
        if (in_acc && fire) begin
          frame_num_r  <= frames_r;
          frame_base_r <= count[AW-1:0];
          ld_cnt_r     <= '0;
        end
      end
      sbe_pkg::ST_LOAD: begin
        if (ld_cnt_r < (AW+1)'(TRANSFORM_POINTS)) ld_cnt_r <= ld_cnt_r + (AW+1)'(1);
        stage_r <= '0;
        bf_r    <= '0;
      end
      sbe_pkg::ST_BF_RD_A: begin
        b_word_r <= w_rdata;
      end
      sbe_pkg::ST_BF_MUL: begin
        a_word_r <= w_rdata;
        p_rc_r <= $signed(b_word_r[63:32]) * $signed(tw_q_r[33:17]);
        p_is_r <= $signed(b_word_r[31:0])  * $signed(tw_q_r[16:0]);
        p_ic_r <= $signed(b_word_r[31:0])  * $signed(tw_q_r[33:17]);
        p_rs_r <= $signed(b_word_r[63:32]) * $signed(tw_q_r[16:0]);
      end
      sbe_pkg::ST_BF_WR_B: begin
        apt_word_r <= {a_re + tr, a_im + ti};
      end
      sbe_pkg::ST_BF_WR_A: begin
        bf_r <= bf_r + (AW-1)'(1);
        if (bf_r == '1) stage_r <= stage_r + SW'(1);
        band_r <= '0;
        bin_r  <= sbe_pkg::BAND_LO[0];
        acc_r  <= '0;
      end
      sbe_pkg::ST_MG_RD: begin
        if (!bin_past && bin_above) bin_r <= bin_r + 8'd1;
      end
      sbe_pkg::ST_MG_MUL: begin
        sq_re_r <= $signed(w_rdata[63:32]) * $signed(w_rdata[63:32]);
        sq_im_r <= $signed(w_rdata[31:0]) * $signed(w_rdata[31:0]);
      end
      sbe_pkg::ST_MG_SQRT: begin
        if (sq_done) begin
          acc_r <= acc_r + 40'(sq_root);
          bin_r <= bin_r + 8'd1;
        end
      end
      sbe_pkg::ST_EMIT: begin
        if (out_free && band_r != 5'(BAND_COUNT - 1)) begin
          band_r <= band_r + 5'd1;
          bin_r  <= sbe_pkg::BAND_LO[band_r + 5'd1];
          acc_r  <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sbe_pkg::ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sbe_pkg::ST_EMIT && out_free) begin
      out_frame_r  <= frame_num_r;
      out_band_r   <= band_r;
      out_energy_r <= (acc_r[39:32] != 8'd0) ? 32'hFFFF_FFFF : acc_r[31:0];
      out_last_r   <= (band_r == 5'(BAND_COUNT - 1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_number = out_frame_r;
  assign out_band_number  = out_band_r;
  assign out_energy       = out_energy_r;
  assign out_last_band    = out_last_r;

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sbe_pkg::ST_EMIT)
    else $error("band beat raised outside the emit state");

  a_last_band: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_band_r == 5'(BAND_COUNT - 1))
    else $error("last band flag on a band other than the top one");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == sbe_pkg::ST_MG_SQRT)
    else $error("square root finished while the sequencer was not waiting");

  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbe_pkg::ST_LOAD && state_nxt == sbe_pkg::ST_BF_RD_B)
      |-> ld_cnt_r == (AW+1)'(TRANSFORM_POINTS))
    else $error("transform started before the frame was fully loaded");

endmodule

// File: tb/sv/tb_stft_band_energy_top.sv
// ----------------------------------------------------------------------------
// tb_stft_band_energy_top: testbench of the STFT band energy filterbank
// Streams PCM samples through several capture lengths, predicts the Hann
// windowed fixed-point FFT band energies of every completed frame and checks
// each band beat against them, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_stft_band_energy_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS      = 512;
  localparam int HOP       = 128;
  localparam int BANDS     = 24;
  localparam int IDLE_LIMIT = 200000;
  localparam longint unsigned PI_FX = 64'd3373259426;

  typedef struct packed {
    logic [8:0]  frame;
    logic [4:0]  band;
    logic [31:0] energy;
    logic        last;
  } band_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_sample;
  logic        out_valid;
  logic        out_stall;
  logic [8:0]  out_frame_number;
  logic [4:0]  out_band_number;
  logic [31:0] out_energy;
  logic        out_last_band;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  stft_band_energy_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_number (out_frame_number),
    .out_band_number  (out_band_number),
    .out_energy       (out_energy),
    .out_last_band    (out_last_band),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  band_beat_t  energy_queue[$];
  int          errors;
  bit          quiet;
  int          idle_cycles;

  int          hann_rom [NPTS];
  longint      cos_rom [NPTS/2];
  longint      sin_rom [NPTS/2];
  int          pcm_store [NPTS];
  longint      fft_re [NPTS];
  longint      fft_im [NPTS];
  int unsigned cap_len;
  int unsigned cap_pos;
  int unsigned frame_cnt;

  function automatic longint rshift_round(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sine_q30(longint unsigned num, longint unsigned den);
    bit neg;
    longint unsigned x, x2, term;
    longint sum;
    neg = 0;
    if (num >= den) begin
      num = num - den;
      neg = 1;
    end
    if (2 * num > den) num = den - num;
    x = num * PI_FX / den;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k & 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return neg ? -sum : sum;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void build_tables();
    longint s;
    longint unsigned sq, w;
    for (int i = 0; i < NPTS; i++) begin
      s = sine_q30(i, NPTS - 1);
      sq = longint'(s * s);
      w = (sq + (64'd1 << 44)) >> 45;
      hann_rom[i] = (w > 32767) ? 32767 : int'(w);
    end
    for (int i = 0; i < NPTS/2; i++) begin
      cos_rom[i] = rshift_round(sine_q30(2 * i + NPTS/2, NPTS), 15);
      sin_rom[i] = rshift_round(sine_q30(2 * i, NPTS), 15);
    end
  endfunction

  function automatic void frame_spectrum(int unsigned count);
    int unsigned j, bt, half, stp, a, b;
    longint t, c, s, tr, ti;
    for (int n = 0; n < NPTS; n++) begin
      fft_re[n] = rshift_round(longint'(pcm_store[(count + n) % NPTS]) * hann_rom[n], 15);
      fft_im[n] = 0;
    end
    j = 0;
    for (int n = 0; n < NPTS - 1; n++) begin
      if (n < j) begin
        t = fft_re[n];
        fft_re[n] = fft_re[j];
        fft_re[j] = t;
      end
      bt = NPTS >> 1;
      while (bt != 0 && (j & bt)) begin
        j = j ^ bt;
        bt = bt >> 1;
      end
      j = j | bt;
    end
    for (int len = 2; len <= NPTS; len = len << 1) begin
      half = len >> 1;
      stp = NPTS / len;
      for (int base = 0; base < NPTS; base += len) begin
        for (int k = 0; k < half; k++) begin
          a = base + k;
          b = a + half;
          c = cos_rom[k * stp];
          s = sin_rom[k * stp];
          tr = rshift_round(fft_re[b] * c + fft_im[b] * s, 15);
          ti = rshift_round(fft_im[b] * c - fft_re[b] * s, 15);
          fft_re[b] = fft_re[a] - tr;
          fft_im[b] = fft_im[a] - ti;
          fft_re[a] = fft_re[a] + tr;
          fft_im[a] = fft_im[a] + ti;
        end
      end
    end
  endfunction

  function automatic void predict_sample(logic [15:0] raw);
    int unsigned len, count;
    longint unsigned acc;
    band_beat_t bb;
    len = (cap_len == 0) ? 65536 : cap_len;
    count = cap_pos + 1;
    pcm_store[cap_pos % NPTS] = $signed(raw);
    if (count >= NPTS && count <= len && (count - NPTS) % HOP == 0) begin
      frame_spectrum(count);
      for (int bn = 0; bn < BANDS; bn++) begin
        acc = 0;
        for (int k = sbe_pkg::BAND_LO[bn]; k <= sbe_pkg::BAND_HI[bn]; k++) begin
          if (k < NPTS/2)
            acc = acc + int_sqrt(longint'(fft_re[k] * fft_re[k] + fft_im[k] * fft_im[k]));
        end
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        bb.frame = frame_cnt[8:0];
        bb.band = bn[4:0];
        bb.energy = acc[31:0];
        bb.last = (bn == BANDS - 1);
        energy_queue.push_back(bb);
      end
      frame_cnt = (frame_cnt + 1) % 512;
    end
    if (count >= len) begin
      cap_pos = 0;
      frame_cnt = 0;
    end else begin
      cap_pos = count & 16'hFFFF;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_sample(input logic [15:0] s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    predict_sample(s);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_input();
    wait (energy_queue.size() == 0);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_capture_length(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_len = v;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_default_capture();
    logic [15:0] pat [12];
    pat = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
            16'hAAAA, 16'h8001, 16'h7FFE, 16'h00FF, 16'hFF00, 16'h1234};
    for (int i = 0; i < 24; i++) send_sample(pat[i % 12]);
    for (int i = 24; i < 520; i++) send_sample(rand_sample());
    wait_drained();
  endtask

  task automatic test_shrink_mid_capture();
    write_capture_length(16'd512);
    send_sample(rand_sample());
    for (int i = 0; i < 512; i++) send_sample(rand_sample());
    wait_drained();
  endtask

  task automatic test_hop_framing();
    write_capture_length(16'd768);
    for (int i = 0; i < 768; i++) begin
      if (i == 600) wait_drained();
      send_sample(rand_sample());
    end
    wait_drained();
  endtask

  task automatic test_long_capture();
    quiet = 1'b1;
    write_capture_length(16'hFFFF);
    for (int i = 0; i < 660; i++) send_sample(rand_sample());
    stop_input();
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (energy_queue.size() == 0) begin
        $display("%0t: unexpected band beat frame %0d band %0d energy %0d", $time,
                 out_frame_number, out_band_number, out_energy);
        errors++;
      end else begin
        if (out_frame_number !== energy_queue[0].frame) begin
          $display("%0t: frame_number expected %0d actual %0d", $time,
                   energy_queue[0].frame, out_frame_number);
          errors++;
        end
        if (out_band_number !== energy_queue[0].band) begin
          $display("%0t: band_number expected %0d actual %0d", $time,
                   energy_queue[0].band, out_band_number);
          errors++;
        end
        if (out_energy !== energy_queue[0].energy) begin
          $display("%0t: energy expected %0d actual %0d", $time,
                   energy_queue[0].energy, out_energy);
          errors++;
        end
        if (out_last_band !== energy_queue[0].last) begin
          $display("%0t: last_band expected %0d actual %0d", $time,
                   energy_queue[0].last, out_last_band);
          errors++;
        end
        void'(energy_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_stft_band_energy_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    in_valid <= 1'b0;
    in_sample <= 16'h0000;
    cfg_valid <= 1'b0;
    cfg_data <= 16'h0000;
    rst_n <= 1'b0;
    cap_len = 16000;
    cap_pos = 0;
    frame_cnt = 0;
    for (int i = 0; i < NPTS; i++) pcm_store[i] = 0;
    build_tables();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_capture();
    test_shrink_mid_capture();
    test_hop_framing();
    test_long_capture();
    wait (energy_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_stft_band_energy_top: done, clean");
    end else begin
      $display("tb_stft_band_energy_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sbe_pkg.sv
rtl/sbe_ram.sv
rtl/sbe_isqrt.sv
rtl/stft_band_energy_top.sv
tb/sv/tb_stft_band_energy_top.sv
